[sv/eps_pkg.sv]
// shared types, constants and table functions of the exponential pitch square oscillator
package eps_pkg;

    localparam int EXP_TABLE_DEPTH_DEFAULT = 256;
    localparam int PHASE_FRAC_BITS_DEFAULT = 16;
    localparam int ROOT_STEPS = 24;
    localparam logic [11:0] DAC_HIGH = 12'd4095;
    localparam logic [11:0] DAC_LOW = 12'd0;

    typedef enum logic [1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_BASE_OFFSET = 2'd1,
        CFG_BASE_SPREAD = 2'd2,
        CFG_SAMPLE_RATE = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_O,
        ST_MUL_S,
        ST_SMOOTH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FRAC,
        ST_TAB,
        ST_INTERP,
        ST_MANT,
        ST_SCALE,
        ST_SHIFT,
        ST_LSHIFT,
        ST_PMOD,
        ST_PWAIT,
        ST_PADD,
        ST_OUT
    } state_t;

    // bitwise integer square root of a 64-bit value
    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = value;
        res = 64'd0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // q30 value of 2^(x / 2^ROOT_STEPS) from a product of roots of two
    function automatic logic [31:0] exp_entry(input logic [63:0] x);
        logic [63:0] c;
        logic [63:0] m;
        c = 64'd1 << 31;
        m = 64'd1 << 30;
        for (int k = 1; k <= ROOT_STEPS; k++)
        begin
            c = isqrt64(c << 30);
            if (((x >> (ROOT_STEPS - k)) & 64'd1) != 64'd0)
            begin
                m = (m * c + (64'd1 << 29)) >> 30;
            end
        end
        return m[31:0];
    endfunction

endpackage

[sv/eps_if.sv]
// sample and result channel interfaces
interface eps_sample_if;
    logic        valid;
    logic        ready;
    logic        sample_due;
    logic [11:0] pd1_pot;
    logic [11:0] pd2_pot;
    logic [11:0] pitch_cv;
    logic [11:0] fine_tune;

    modport source (output valid, sample_due, pd1_pot, pd2_pot, pitch_cv, fine_tune,
                    input ready);
    modport sink (input valid, sample_due, pd1_pot, pd2_pot, pitch_cv, fine_tune,
                  output ready);
endinterface

interface eps_result_if;
    logic               valid;
    logic               ready;
    logic        [11:0] dac_level;
    logic signed [15:0] offset_trim_out;
    logic signed [13:0] spread_trim_out;

    modport source (output valid, dac_level, offset_trim_out, spread_trim_out, input ready);
    modport sink (input valid, dac_level, offset_trim_out, spread_trim_out, output ready);
endinterface

[sv/eps_div.sv]
// serial restoring divider, one quotient bit per cycle
module eps_div #(
    parameter int W = 37
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W:0]    shifted;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign fits = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CW'(W);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? W'(shifted - {1'b0, dsr_reg}) : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;
endmodule

[sv/exp_pitch_square_oscillator.sv]
// Exponential pitch square oscillator. Each accepted transaction with sample_due set while
// the enable setting is 1 smooths the four readings, converts pitch to frequency through
// 2^exponent and advances a phase accumulator, then delivers one result; other
// transactions are dropped with no result. The block works on one transaction at a time;
// the exponent is formed by the serial divider, one quotient bit per cycle, and after
// sample_rate is lowered below the held phase, the next tick also uses the same divider
// to reduce the phase. A finished result waits in an output register while the next
// transaction is taken.
module exp_pitch_square_oscillator #(
    parameter int EXP_TABLE_DEPTH = eps_pkg::EXP_TABLE_DEPTH_DEFAULT,
    parameter int PHASE_FRAC_BITS = eps_pkg::PHASE_FRAC_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  eps_pkg::cfg_index_t cfg_index,
    input  logic [17:0]         cfg_data,
    eps_sample_if.sink          sample,
    eps_result_if.source        result
);
    import eps_pkg::*;

    localparam int PW = 18 + PHASE_FRAC_BITS;
    localparam int DW = (PW > 37) ? PW : 37;
    localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int IW = $clog2(EXP_TABLE_DEPTH);
    localparam logic [22:0] E_MAX = 23'd1 << 22;

    // constant fraction table, q30
    logic [31:0] exp_tab [EXP_TABLE_DEPTH + 1];
    for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++)
    begin : g_tab
        localparam logic [63:0] X = (64'(gi) << ROOT_STEPS) / EXP_TABLE_DEPTH;
        localparam logic [31:0] V = (gi == EXP_TABLE_DEPTH) ? 32'h8000_0000 : exp_entry(X);
        assign exp_tab[gi] = V;
    end

    state_t state_reg, state_next;

    logic               enable_reg;
    logic        [12:0] base_offset_reg;
    logic signed [12:0] base_spread_reg;
    logic        [17:0] sample_rate_reg;

    logic signed [15:0] offset_trim_reg, offset_trim_next;
    logic signed [13:0] spread_trim_reg, spread_trim_next;
    logic        [19:0] pitch_avg_reg, pitch_avg_next;
    logic        [19:0] fine_avg_reg, fine_avg_next;
    logic      [PW-1:0] phase_reg, phase_next;

    logic [11:0] pd1_reg, pd2_reg, cv_reg, fine_reg;
    logic [63:0] prod_reg, prod_next;
    logic signed [15:0] offx_reg, offx_next;
    logic        neg_reg, neg_next;
    logic signed [23:0] e_reg, e_next;
    logic [31:0] lo_reg, lo_next, hi_reg, hi_next, mant_reg, mant_next;
    logic [15:0] sub_reg, sub_next;
    logic [PW-1:0] inc_reg, inc_next, limsh_reg, limsh_next;

    logic        out_valid_reg, out_valid_next;
    logic [11:0] dac_reg, dac_next;
    logic signed [15:0] ot_out_reg, ot_out_next;
    logic signed [13:0] st_out_reg, st_out_next;

    logic [31:0] mul_a, mul_b;

    logic          div_start;
    logic [DW-1:0] div_dividend, div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quo, div_rem;

    eps_div #(.W(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // trim pot scaling: floor(d*64/5) and floor(d*64/25) by reciprocal, offset made positive
    logic signed [12:0] d1, d2;
    logic        [17:0] u1, u2;
    logic        [15:0] q1;
    logic        [13:0] q2;
    logic signed [13:0] x2;
    assign d1 = $signed({1'b0, pd1_reg}) - 13'sd2048;
    assign d2 = $signed({1'b0, pd2_reg}) - 13'sd2048;
    assign u1 = 18'($signed({d1, 6'b0}) + 20'sd131075);
    assign u2 = 18'($signed({d2, 6'b0}) + 20'sd131075);
    assign q1 = prod_reg[33:18];
    assign q2 = prod_reg[36:23];
    assign x2 = 14'($signed({1'b0, q2}) - 15'sd5243);

    // smoothers y = (31y + x + 16) >> 5
    logic signed [21:0] ot_sum;
    logic signed [19:0] st_sum;
    logic        [25:0] pa_sum, fa_sum;
    assign ot_sum = (22'(offset_trim_reg) <<< 5) - 22'(offset_trim_reg) + 22'(offx_reg)
                    + 22'sd16;
    assign st_sum = (20'(spread_trim_reg) <<< 5) - 20'(spread_trim_reg) + 20'(x2) + 20'sd16;
    assign pa_sum = (26'(pitch_avg_reg) << 5) - 26'(pitch_avg_reg) + 26'({cv_reg, 8'b0})
                    + 26'd16;
    assign fa_sum = (26'(fine_avg_reg) << 5) - 26'(fine_avg_reg) + 26'({fine_reg, 8'b0})
                    + 26'd16;

    // exponent operands
    logic signed [21:0] fdiff, adj;
    logic signed [22:0] div_val;
    logic        [21:0] mag_adj;
    logic        [22:0] mag_div;
    assign fdiff = 22'sd524288 - $signed({2'b0, fine_avg_reg});
    assign adj = $signed({2'b0, pitch_avg_reg}) + (fdiff >>> 5);
    assign div_val = 23'($signed({base_spread_reg, 8'b0})) + 23'(spread_trim_reg);
    assign mag_adj = adj[21] ? 22'(-adj) : 22'(adj);
    assign mag_div = div_val[22] ? 23'(-div_val) : 23'(div_val);

    // floor correction and clamp to +-64 octaves
    logic [DW:0]   qe;
    logic [22:0]   e_mag;
    assign qe = {1'b0, div_quo} + (DW + 1)'(neg_reg && (div_rem != '0));
    assign e_mag = (qe > (DW + 1)'(E_MAX)) ? E_MAX : qe[22:0];

    logic signed [7:0] ip;
    logic signed [9:0] s_amt;
    logic        [5:0] ns;
    assign ip = e_reg[23:16];
    assign s_amt = 10'(38 - PHASE_FRAC_BITS) - 10'(ip);
    assign ns = 6'(-s_amt);

    logic [TW-1:0] idx;
    assign idx = TW'(prod_reg[16 +: IW]);

    logic signed [22:0] scale;
    logic               scale_pos;
    assign scale = $signed({2'b0, base_offset_reg, 8'b0}) + 23'(offset_trim_reg);
    assign scale_pos = !scale[22] && (scale != 23'sd0);

    logic [PW-1:0] limit, lim1, half;
    logic [63:0]   shr;
    logic [PW:0]   psum;
    assign limit = {sample_rate_reg, {PHASE_FRAC_BITS{1'b0}}};
    assign lim1 = PW'(limit - 1'b1);
    assign half = PW'({sample_rate_reg, {(PHASE_FRAC_BITS - 1){1'b0}}});
    assign shr = (s_amt >= 10'sd64) ? 64'd0 : (prod_reg >> s_amt[5:0]);
    assign psum = {1'b0, phase_reg} + {1'b0, inc_reg};

    assign sample.ready = (state_reg == ST_IDLE);
    assign prod_next = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        offset_trim_next = offset_trim_reg;
        spread_trim_next = spread_trim_reg;
        pitch_avg_next = pitch_avg_reg;
        fine_avg_next = fine_avg_reg;
        phase_next = phase_reg;
        offx_next = offx_reg;
        neg_next = neg_reg;
        e_next = e_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        sub_next = sub_reg;
        mant_next = mant_reg;
        inc_next = inc_reg;
        limsh_next = limsh_reg;
        out_valid_next = out_valid_reg;
        dac_next = dac_reg;
        ot_out_next = ot_out_reg;
        st_out_next = st_out_reg;
        mul_a = 32'd0;
        mul_b = 32'd0;
        div_start = 1'b0;
        div_dividend = DW'({mag_adj, 16'b0});
        div_divisor = DW'(mag_div);

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid && enable_reg && sample.sample_due)
                begin
                    state_next = ST_MUL_O;
                end
            end
            ST_MUL_O:
            begin
                mul_a = 32'(u1);
                mul_b = 32'd52429;
                state_next = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                offx_next = 16'($signed({1'b0, q1}) - 17'sd26215);
                mul_a = 32'(u2);
                mul_b = 32'd335545;
                state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                offset_trim_next = 16'(ot_sum >>> 5);
                spread_trim_next = 14'(st_sum >>> 5);
                pitch_avg_next = 20'(pa_sum >> 5);
                fine_avg_next = 20'(fa_sum >> 5);
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                neg_next = adj[21] ^ div_val[22];
                if (div_val == 23'sd0)
                begin
                    e_next = 24'sd0;
                    state_next = ST_FRAC;
                end
                else
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    e_next = neg_reg ? -$signed({1'b0, e_mag}) : $signed({1'b0, e_mag});
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                mul_a = 32'(e_reg[15:0]);
                mul_b = 32'(EXP_TABLE_DEPTH);
                state_next = ST_TAB;
            end
            ST_TAB:
            begin
                lo_next = exp_tab[idx];
                hi_next = exp_tab[TW'(idx + 1'b1)];
                sub_next = prod_reg[15:0];
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                mul_a = hi_reg - lo_reg;
                mul_b = 32'(sub_reg);
                state_next = ST_MANT;
            end
            ST_MANT:
            begin
                mant_next = lo_reg + prod_reg[47:16];
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_a = 32'(scale[21:0]);
                mul_b = mant_reg;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // keep the product for the left-shift path
                mul_a = 32'(scale[21:0]);
                mul_b = mant_reg;
                if (!scale_pos || (limit == '0))
                begin
                    inc_next = '0;
                    state_next = ST_PMOD;
                end
                else if (!s_amt[9])
                begin
                    inc_next = (shr > 64'(lim1)) ? lim1 : PW'(shr);
                    state_next = ST_PMOD;
                end
                else
                begin
                    limsh_next = lim1 >> ns;
                    state_next = ST_LSHIFT;
                end
            end
            ST_LSHIFT:
            begin
                inc_next = (prod_reg > 64'(limsh_reg)) ? lim1 : PW'(prod_reg[PW-1:0] << ns);
                state_next = ST_PMOD;
            end
            ST_PMOD:
            begin
                div_dividend = DW'(phase_reg);
                div_divisor = DW'(limit);
                if (limit == '0)
                begin
                    phase_next = '0;
                    state_next = ST_OUT;
                end
                else if (phase_reg >= limit)
                begin
                    div_start = 1'b1;
                    state_next = ST_PWAIT;
                end
                else
                begin
                    state_next = ST_PADD;
                end
            end
            ST_PWAIT:
            begin
                if (div_done)
                begin
                    phase_next = PW'(div_rem);
                    state_next = ST_PADD;
                end
            end
            ST_PADD:
            begin
                phase_next = (psum >= {1'b0, limit}) ? PW'(psum - {1'b0, limit}) : PW'(psum);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    dac_next = ((limit != '0) && (phase_reg > half)) ? DAC_HIGH : DAC_LOW;
                    ot_out_next = offset_trim_reg;
                    st_out_next = spread_trim_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            offset_trim_reg <= '0;
            spread_trim_reg <= '0;
            pitch_avg_reg <= '0;
            fine_avg_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            offset_trim_reg <= offset_trim_next;
            spread_trim_reg <= spread_trim_next;
            pitch_avg_reg <= pitch_avg_next;
            fine_avg_reg <= fine_avg_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            base_offset_reg <= 13'd2299;
            base_spread_reg <= -13'sd583;
            sample_rate_reg <= 18'd48000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENABLE:      enable_reg <= cfg_data[0];
                CFG_BASE_OFFSET: base_offset_reg <= cfg_data[12:0];
                CFG_BASE_SPREAD: base_spread_reg <= $signed(cfg_data[12:0]);
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                default:         enable_reg <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            pd1_reg <= sample.pd1_pot;
            pd2_reg <= sample.pd2_pot;
            cv_reg <= sample.pitch_cv;
            fine_reg <= sample.fine_tune;
        end
        prod_reg <= prod_next;
        offx_reg <= offx_next;
        neg_reg <= neg_next;
        e_reg <= e_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        sub_reg <= sub_next;
        mant_reg <= mant_next;
        inc_reg <= inc_next;
        limsh_reg <= limsh_next;
        dac_reg <= dac_next;
        ot_out_reg <= ot_out_next;
        st_out_reg <= st_out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.dac_level = dac_reg;
    assign result.offset_trim_out = ot_out_reg;
    assign result.spread_trim_out = st_out_reg;
endmodule

[tb/sv/exp_pitch_square_oscillator_tb.sv]
// testbench for the exponential pitch square oscillator with a predicting scoreboard
`timescale 1ns / 1ps

typedef struct packed {
    logic [11:0] dac_level;
    logic [15:0] offset_trim;
    logic [13:0] spread_trim;
} tone_t;

class osc_scoreboard;
    logic [31:0] pow2_frac [0:256];
    bit enable;
    longint offset_base;
    longint spread_base;
    longint unsigned rate;
    longint trim_offset;
    longint trim_spread;
    longint pitch_smooth;
    longint fine_smooth;
    longint unsigned acc_phase;
    tone_t tone_q[$];
    int errors;

    function longint fdiv(longint a, longint b);
        longint q;
        longint r;
        q = a / b;
        r = a % b;
        if (r != 0 && ((r < 0) != (b < 0)))
            q = q - 1;
        return q;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function new();
        longint unsigned roots [1:24];
        longint unsigned c;
        longint unsigned m;
        longint unsigned x;
        c = 64'd1 << 31;
        for (int k = 1; k <= 24; k++)
        begin
            c = root_floor(c << 30);
            roots[k] = c;
        end
        for (int i = 0; i < 256; i++)
        begin
            x = (longint'(i) << 24) / 256;
            m = 64'd1 << 30;
            for (int k = 1; k <= 24; k++)
                if (((x >> (24 - k)) & 1) != 0)
                    m = (m * roots[k] + (64'd1 << 29)) >> 30;
            pow2_frac[i] = m[31:0];
        end
        pow2_frac[256] = 32'h8000_0000;
        enable = 0;
        offset_base = 2299;
        spread_base = -583;
        rate = 48000;
        trim_offset = 0;
        trim_spread = 0;
        pitch_smooth = 0;
        fine_smooth = 0;
        acc_phase = 0;
        errors = 0;
    endfunction

    // works out the tone sample caused by one accepted transaction
    function void note_sample(logic due, logic [11:0] pd1, logic [11:0] pd2,
                              logic [11:0] cv, logic [11:0] ft);
        longint adj;
        longint dv;
        longint e;
        longint ip;
        longint f;
        longint scale;
        int sh;
        longint unsigned idx;
        longint unsigned sub;
        longint unsigned mant;
        longint unsigned lim;
        longint unsigned prod;
        longint unsigned inc;
        tone_t t;
        if (!enable || !due)
            return;
        trim_offset = fdiv(31 * trim_offset + fdiv((longint'(pd1) - 2048) * 256, 20) + 16, 32);
        trim_spread = fdiv(31 * trim_spread + fdiv((longint'(pd2) - 2048) * 256, 100) + 16, 32);
        pitch_smooth = (31 * pitch_smooth + (longint'(cv) << 8) + 16) / 32;
        fine_smooth = (31 * fine_smooth + (longint'(ft) << 8) + 16) / 32;
        adj = pitch_smooth + fdiv(524288 - fine_smooth, 32);
        dv = spread_base * 256 + trim_spread;
        e = (dv == 0) ? 0 : fdiv(adj * 65536, dv);
        if (e > (64 <<< 16))
            e = 64 <<< 16;
        if (e < -(64 <<< 16))
            e = -(64 <<< 16);
        ip = fdiv(e, 65536);
        f = e - ip * 65536;
        idx = (f * 256) >> 16;
        sub = (f * 256) & 16'hFFFF;
        mant = longint'(pow2_frac[idx]) +
               (((longint'(pow2_frac[idx + 1]) - longint'(pow2_frac[idx])) * sub) >> 16);
        lim = rate << 16;
        scale = offset_base * 256 + trim_offset;
        inc = 0;
        if (scale > 0 && lim > 0)
        begin
            prod = longint'(scale) * mant;
            sh = 22 - ip;
            if (sh >= 64)
                inc = 0;
            else if (sh >= 0)
                inc = prod >> sh;
            else if (prod > ((lim - 1) >> (-sh)))
                inc = lim - 1;
            else
                inc = prod << (-sh);
            if (inc > lim - 1)
                inc = lim - 1;
        end
        if (lim == 0)
            acc_phase = 0;
        else
            acc_phase = ((acc_phase % lim) + inc) % lim;
        t.dac_level = (lim != 0 && acc_phase > (rate << 15)) ? eps_pkg::DAC_HIGH
                                                              : eps_pkg::DAC_LOW;
        t.offset_trim = trim_offset[15:0];
        t.spread_trim = trim_spread[13:0];
        tone_q.push_back(t);
    endfunction

    function void check_tone(tone_t got);
        tone_t want;
        if (tone_q.size() == 0)
        begin
            $display("%0t: unexpected result dac=%0d ot=%0d st=%0d", $time,
                     got.dac_level, $signed(got.offset_trim), $signed(got.spread_trim));
            errors++;
            return;
        end
        want = tone_q.pop_front();
        if (want.dac_level !== got.dac_level)
        begin
            $display("%0t: dac_level expected %0d actual %0d", $time,
                     want.dac_level, got.dac_level);
            errors++;
        end
        if (want.offset_trim !== got.offset_trim)
        begin
            $display("%0t: offset_trim_out expected %0d actual %0d", $time,
                     $signed(want.offset_trim), $signed(got.offset_trim));
            errors++;
        end
        if (want.spread_trim !== got.spread_trim)
        begin
            $display("%0t: spread_trim_out expected %0d actual %0d", $time,
                     $signed(want.spread_trim), $signed(got.spread_trim));
            errors++;
        end
    endfunction
endclass

module exp_pitch_square_oscillator_tb;
    import eps_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    cfg_index_t  cfg_index;
    logic [17:0] cfg_data;

    eps_sample_if sample ();
    eps_result_if result ();

    exp_pitch_square_oscillator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample.sink),
        .result    (result.source)
    );

    osc_scoreboard sb;
    int send_pct;
    int recv_pct;
    bit hold_req;
    int hold_cnt;
    int quiet_cnt;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver side, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= recv_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && sample.valid && sample.ready)
            sb.note_sample(sample.sample_due, sample.pd1_pot, sample.pd2_pot,
                           sample.pitch_cv, sample.fine_tune);
        if (rst_n && result.valid && result.ready)
            sb.check_tone({result.dac_level, result.offset_trim_out, result.spread_trim_out});
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready))
            quiet_cnt = 0;
        else
            quiet_cnt++;
        if (quiet_cnt >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(logic due, logic [11:0] pd1, logic [11:0] pd2,
                        logic [11:0] cv, logic [11:0] ft);
        while ($urandom_range(99) < send_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.sample_due <= due;
        sample.pd1_pot <= pd1;
        sample.pd2_pot <= pd2;
        sample.pitch_cv <= cv;
        sample.fine_tune <= ft;
        do
            @(posedge clk);
        while (!sample.ready);
    endtask

    task automatic send_random();
        logic [11:0] f [4];
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(9))
                0: f[i] = 12'd0;
                1: f[i] = 12'd4095;
                2: f[i] = 12'd2048;
                default: f[i] = $urandom_range(4095);
            endcase
        end
        send($urandom_range(9) != 0, f[0], f[1], f[2], f[3]);
    endtask

    // lets every expected result arrive, then lets the block settle
    task automatic drain();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (sb.tone_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(cfg_index_t idx, longint v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[17:0];
        case (idx)
            CFG_ENABLE:      sb.enable = v[0];
            CFG_BASE_OFFSET: sb.offset_base = v[12:0];
            CFG_BASE_SPREAD: sb.spread_base = longint'($signed(v[12:0]));
            CFG_SAMPLE_RATE: sb.rate = v[17:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        longint pick;
        sb = new();
        send_pct = 0;
        recv_pct = 0;
        hold_req = 0;
        hold_cnt = 0;
        quiet_cnt = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        sample.valid = 1'b0;
        sample.sample_due = 1'b0;
        sample.pd1_pot = '0;
        sample.pd2_pot = '0;
        sample.pitch_cv = '0;
        sample.fine_tune = '0;
        result.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled: ticks are dropped
        send(1, 12'd4095, 12'd0, 12'd4095, 12'd0);
        send(1, 12'd0, 12'd4095, 12'd0, 12'd4095);
        drain();
        cfg_put(CFG_ENABLE, 1);
        // zero divisor with the spread trim still at zero
        cfg_put(CFG_BASE_SPREAD, 0);
        send(1, 12'd2048, 12'd2048, 12'd1000, 12'd2048);
        drain();
        cfg_put(CFG_BASE_SPREAD, -583);
        send(0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send(1, 12'd0, 12'd0, 12'd0, 12'd0);
        send(1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send(1, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
        send(1, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
        drain();
        // non-positive scale
        cfg_put(CFG_BASE_OFFSET, 0);
        send(1, 12'd0, 12'd2048, 12'd2048, 12'd2048);
        send(1, 12'd0, 12'd2048, 12'd4095, 12'd0);
        drain();
        // positive spread drives the exponent into its upper clamp
        cfg_put(CFG_BASE_OFFSET, 8191);
        cfg_put(CFG_BASE_SPREAD, 1);
        send(1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send(1, 12'd4095, 12'd4095, 12'd4095, 12'd0);
        drain();
        cfg_put(CFG_BASE_SPREAD, -128);
        send(1, 12'd4095, 12'd0, 12'd4095, 12'd0);
        send(1, 12'd4095, 12'd0, 12'd4095, 12'd0);
        drain();
        // zero rate, then a high rate lowered under the held phase
        cfg_put(CFG_SAMPLE_RATE, 0);
        send(1, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
        drain();
        cfg_put(CFG_SAMPLE_RATE, 192000);
        cfg_put(CFG_BASE_SPREAD, -4095);
        for (int i = 0; i < 4; i++)
            send(1, 12'd4095, 12'd2048, 12'd0, 12'd4095);
        drain();
        cfg_put(CFG_SAMPLE_RATE, 8000);
        send(1, 12'd2048, 12'd2048, 12'd3000, 12'd2048);
        send(1, 12'd2048, 12'd2048, 12'd3000, 12'd2048);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 56; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 56; end
                default: begin send_pct = 8; recv_pct = 8; end
            endcase
            cfg_put(CFG_ENABLE, 1);
            case ($urandom_range(3))
                0: pick = 0;
                1: pick = 8191;
                default: pick = $urandom_range(8191);
            endcase
            cfg_put(CFG_BASE_OFFSET, pick);
            case ($urandom_range(3))
                0: pick = -4095;
                1: pick = -128;
                default: pick = -longint'($urandom_range(4095, 128));
            endcase
            cfg_put(CFG_BASE_SPREAD, pick);
            case ($urandom_range(3))
                0: pick = 8000;
                1: pick = 192000;
                default: pick = $urandom_range(192000, 8000);
            endcase
            cfg_put(CFG_SAMPLE_RATE, pick);
            if (ph == 0)
                hold_req = 1;
            for (int n = 0; n < 50; n++)
            begin
                send_random();
                // pause the sender mid-phase until the block has caught up
                if (ph == 1 && n == 25)
                    drain();
            end
            drain();
        end
        cfg_put(CFG_ENABLE, 0);
        send(1, 12'd100, 12'd200, 12'd300, 12'd400);
        drain();

        if (sb.errors == 0 && sb.tone_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
